@@ sv/double_ended_queue_top_defines.svh @@
// assertion macros for the double-ended queue
// each one expects clk and arst_n in the scope where it is used
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define DEQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/deq_pkg.sv @@
// ---------------------------------------------------------------------------
// deq_pkg
// shared types and constants of the double-ended queue
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int OCC_W     = 5;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK_FRONT = 3'd4,
		CMD_PEEK_BACK  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// result of one transaction, minus the item read from the store
	typedef struct packed {
		logic             done;
		logic             rd_used;
		status_t          status;
		logic             is_empty;
		logic [OCC_W-1:0] occupancy;
	} resp_t;

endpackage

`default_nettype wire

@@ sv/deq_mem.sv @@
// ---------------------------------------------------------------------------
// deq_mem
// item store: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_mem
	import deq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/deq_ctrl.sv @@
// ---------------------------------------------------------------------------
// deq_ctrl
// head pointer and item count, store access and registered status
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl
	import deq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [2:0]    cmd,
	output logic               we,
	output logic [AW-1:0]      waddr,
	output logic               re,
	output logic [AW-1:0]      raddr,
	output resp_t              resp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = AW + 1;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	resp_t         resp_s1;

	logic [AW-1:0] head_d;
	logic [CW-1:0] count_d;
	status_t       status_d;
	logic          rd_used_d;
	logic          full;
	logic          empty;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] head_dec;
	logic [SW-1:0] tail_sum;
	logic [SW-1:0] back_sum;
	logic [AW-1:0] tail_slot;
	logic [AW-1:0] back_slot;

	always_comb begin
		full     = (count_q == CW'(DEPTH));
		empty    = (count_q == '0);
		head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
		head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
		// ring sums stay below twice the depth, one subtract wraps them
		tail_sum  = SW'(head_q) + SW'(count_q);
		back_sum  = tail_sum - SW'(1);
		tail_slot = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
		back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
	end

	always_comb begin
		head_d    = head_q;
		count_d   = count_q;
		status_d  = ST_OK;
		rd_used_d = 1'b0;
		we        = 1'b0;
		waddr     = tail_slot;
		re        = 1'b0;
		raddr     = head_q;
		if (accept) begin
			unique case (cmd)
				CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						we      = 1'b1;
						count_d = count_q + CW'(1);
						if (cmd == CMD_PUSH_FRONT) begin
							head_d = head_dec;
							waddr  = head_dec;
						end
					end
				end
				CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
					if (empty) begin
						status_d = ST_EMPTY;
					end else begin
						re        = 1'b1;
						rd_used_d = 1'b1;
						if (cmd == CMD_POP_BACK || cmd == CMD_PEEK_BACK) begin
							raddr = back_slot;
						end
						if (cmd == CMD_POP_FRONT) begin
							head_d  = head_inc;
							count_d = count_q - CW'(1);
						end else if (cmd == CMD_POP_BACK) begin
							count_d = count_q - CW'(1);
						end
					end
				end
				default: begin
					// unused command codes leave the queue alone
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			resp_s1 <= '0;
		end else begin
			head_q            <= head_d;
			count_q           <= count_d;
			resp_s1.done      <= accept;
			resp_s1.rd_used   <= rd_used_d;
			resp_s1.status    <= status_d;
			resp_s1.is_empty  <= (count_d == '0);
			resp_s1.occupancy <= OCC_W'(count_d);
		end
	end

	assign resp = resp_s1;

endmodule

`default_nettype wire

@@ sv/double_ended_queue_top.sv @@
// a result appears in the cycle after its transaction is accepted
// throughput: one transaction per cycle; busy is never raised
// the store is read in the accept cycle and its registered output feeds data
// reset clears head and count; the store itself is not cleared
// results are shown for one cycle with done and cannot be held off
// ---------------------------------------------------------------------------
// double_ended_queue_top
// bounded double-ended queue of signed 32-bit items in a ring store
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_queue_top_defines.svh"

module double_ended_queue_top
	import deq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [2:0]               cmd,
	input  wire logic signed [DATA_W-1:0] value,
	output logic                          done,
	output logic signed [DATA_W-1:0]      data,
	output logic [1:0]                    status,
	output logic                          is_empty,
	output logic [OCC_W-1:0]              occupancy
);

	localparam int AW = $clog2(DEPTH);

	logic              accept;
	logic              we;
	logic              re;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic [DATA_W-1:0] rdata;
	resp_t             resp;

	// every command finishes in one pass through the store
	assign busy   = 1'b0;
	assign accept = start && !busy;

	deq_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cmd    (cmd),
		.we     (we),
		.waddr  (waddr),
		.re     (re),
		.raddr  (raddr),
		.resp   (resp)
	);

	deq_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (value),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign done      = resp.done;
	assign data      = resp.rd_used ? rdata : '0;
	assign status    = resp.status;
	assign is_empty  = resp.is_empty;
	assign occupancy = resp.occupancy;

	`DEQ_ASSERT_NEXT(a_result_follows, accept, done, "accepted transaction gave no result")
	`DEQ_ASSERT_NEXT(a_no_stray_result, !accept, !done, "result without a transaction")
	`DEQ_ASSERT_NOW(a_empty_status, done && status == ST_EMPTY, is_empty && data == '0, "empty status on a non-empty queue")
	`DEQ_ASSERT_NOW(a_full_status, done && status == ST_FULL, !is_empty && data == '0, "full status with bad flags")

endmodule

`default_nettype wire

@@ bench/deq_checker.sv @@
// ---------------------------------------------------------------------------
// deq_checker
// watches the command and result ports of the double-ended queue, keeps its
// own ring of held items to work out each result, and compares every result
// field by field with the oldest outstanding one
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_checker
	import deq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [2:0]               cmd,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     done,
	input  logic signed [DATA_W-1:0] data,
	input  logic [1:0]               status,
	input  logic                     is_empty,
	input  logic [OCC_W-1:0]         occupancy,
	output int                       fail_count,
	output int                       pending
);

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		status_t                  status;
		logic                     is_empty;
		logic [OCC_W-1:0]         occupancy;
	} deq_result_t;

	logic signed [DATA_W-1:0] ring [DEPTH];
	int front;
	int held;
	deq_result_t awaited_q [$];
	int mismatches = 0;
	int outstanding = 0;

	assign fail_count = mismatches;
	assign pending    = outstanding;

	// apply one command to the modeled queue and return the result it gives
	function automatic deq_result_t apply_command(input logic [2:0] op,
			input logic signed [DATA_W-1:0] item);
		deq_result_t r;
		int slot;
		r.data   = '0;
		r.status = ST_OK;
		case (op)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (held >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					if (op == CMD_PUSH_FRONT) begin
						front = (front + DEPTH - 1) % DEPTH;
						ring[front] = item;
					end else begin
						ring[(front + held) % DEPTH] = item;
					end
					held++;
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					slot = (op == CMD_POP_FRONT || op == CMD_PEEK_FRONT) ? front
						: (front + held - 1) % DEPTH;
					r.data = ring[slot];
					if (op == CMD_POP_FRONT) begin
						front = (front + 1) % DEPTH;
						held--;
					end else if (op == CMD_POP_BACK) begin
						held--;
					end
				end
			end
			default: begin
				// unused command codes leave the queue alone
			end
		endcase
		r.is_empty  = (held == 0);
		r.occupancy = OCC_W'(held);
		return r;
	endfunction

	function automatic void check_field(input string field, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		deq_result_t want;
		if (!arst_n) begin
			front = 0;
			held  = 0;
			awaited_q.delete();
			outstanding <= 0;
		end else begin
			if (done) begin
				if (awaited_q.size() == 0) begin
					$display("%0t: result seen with no transaction outstanding", $time);
					mismatches++;
				end else begin
					want = awaited_q.pop_front();
					check_field("data", want.data, data);
					check_field("status", want.status, status);
					check_field("is_empty", want.is_empty, is_empty);
					check_field("occupancy", want.occupancy, occupancy);
				end
			end
			if (start && !busy)
				awaited_q.push_back(apply_command(cmd, value));
			// published a step late so the stimulus side reads it without a race
			outstanding <= awaited_q.size();
		end
	end

endmodule

@@ bench/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// drives commands into the double-ended queue: a directed run over empty,
// full and unused-code cases, then biased random phases that sweep the queue
// between empty and full under varying sender idling
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import deq_pkg::*;

	localparam logic [2:0] CMD_RSVD_6 = 3'd6;
	localparam logic [2:0] CMD_RSVD_7 = 3'd7;
	localparam int PHASE_ITEMS = 460;
	localparam int SEGMENT_ITEMS = 32;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [2:0] cmd;
	logic signed [DATA_W-1:0] value;
	logic done;
	logic signed [DATA_W-1:0] data;
	logic [1:0] status;
	logic is_empty;
	logic [OCC_W-1:0] occupancy;
	int fail_count;
	int pending;
	int cycle_count = 0;
	int idle_pct = 0;
	int push_pct;
	int idle_plan [4] = '{0, 56, 28, 0};

	always #5 clk = ~clk;

	double_ended_queue_top #(.DEPTH(DEPTH_DEF)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .value(value),
		.done(done), .data(data), .status(status), .is_empty(is_empty),
		.occupancy(occupancy)
	);

	deq_checker #(.DEPTH(DEPTH_DEF)) checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .value(value),
		.done(done), .data(data), .status(status), .is_empty(is_empty),
		.occupancy(occupancy), .fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// start stays high into the next transaction unless an idle gap is drawn
	task automatic issue_command(input logic [2:0] c, input logic signed [DATA_W-1:0] v);
		start <= 1'b1;
		cmd   <= c;
		value <= v;
		do @(posedge clk); while (busy);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic wait_all_returned();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_item();
		case ($urandom_range(31))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [2:0] pick_command(input int push_bias);
		if ($urandom_range(99) < 2)
			return $urandom_range(1) ? CMD_RSVD_7 : CMD_RSVD_6;
		if ($urandom_range(99) < push_bias)
			return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
		case ($urandom_range(3))
			0: return CMD_POP_FRONT;
			1: return CMD_POP_BACK;
			2: return CMD_PEEK_FRONT;
			default: return CMD_PEEK_BACK;
		endcase
	endfunction

	initial begin
		arst_n <= 1'b0;
		start  <= 1'b0;
		cmd    <= CMD_PUSH_FRONT;
		value  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: every read reports empty, unused codes do nothing
		issue_command(CMD_POP_FRONT, '0);
		issue_command(CMD_POP_BACK, '0);
		issue_command(CMD_PEEK_FRONT, '0);
		issue_command(CMD_PEEK_BACK, '0);
		issue_command(CMD_RSVD_6, 32'sh7fffffff);
		issue_command(CMD_RSVD_7, 32'sh80000000);
		// fill to the brim from both ends, then push into a full queue
		issue_command(CMD_PUSH_FRONT, 32'sh7fffffff);
		issue_command(CMD_PUSH_BACK, 32'sh80000000);
		issue_command(CMD_PEEK_FRONT, '0);
		issue_command(CMD_PEEK_BACK, '0);
		repeat (DEPTH_DEF - 2)
			issue_command($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_item());
		issue_command(CMD_PUSH_FRONT, -32'sd1);
		issue_command(CMD_PUSH_BACK, '0);
		issue_command(CMD_PEEK_BACK, '0);
		wait_all_returned();

		// random phases; each segment leans toward filling, draining or neither
		foreach (idle_plan[p]) begin
			idle_pct = idle_plan[p];
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % SEGMENT_ITEMS == 0) begin
					case ($urandom_range(2))
						0: push_pct = 15;
						1: push_pct = 50;
						default: push_pct = 85;
					endcase
				end
				issue_command(pick_command(push_pct), pick_item());
			end
			wait_all_returned();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
